[hdl/b2r_pkg.sv]
// Shared types and constants for the BMP24 to RGB565 pixel writer.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package b2r_pkg;

  // Largest image dimension accepted; larger header values saturate to it.
  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned BYTES_PER_PIXEL = 3;

  localparam int unsigned DIM_W = 13;
  localparam int unsigned ADDR_W = 25;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_TOP_FIRST     = 3'd2,
    REG_DEST_X        = 3'd3,
    REG_DEST_Y        = 3'd4,
    REG_SCREEN_WIDTH  = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6,
    REG_LINE_STRIDE   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } byte_phase_e;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             top_first;
    logic [DIM_W-1:0] dest_x;
    logic [DIM_W-1:0] dest_y;
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
    logic [DIM_W-1:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] pixel_address;
    logic [15:0]       pixel_rgb565;
    logic              image_done;
  } out_item_t;

  // Pixel event handed from the byte parser to the address stage.
  typedef struct packed {
    logic             on_screen;
    logic [DIM_W-1:0] pix_col;
    logic [DIM_W-1:0] pix_row;
    logic [15:0]      rgb565;
    logic             image_done;
  } pix_event_t;

endpackage

[hdl/bmp24_to_rgb565_pixel_writer.sv]
// Top level of the BMP24 to RGB565 pixel writer: configuration registers,
// byte parser and the address stage with the output register. Uses b2r_pkg.
`timescale 1ns / 1ps

// Usage:
// - Software writes the header values through cfg_we_i/cfg_index_i/cfg_data_i
//   while no transfer is in flight; a write takes effect at the next edge.
// - The input channel carries one byte of BMP pixel data per transfer, padding
//   included; start_image marks the first byte of an image.
// - The output channel carries one result per finished pixel and one for a
//   final pad byte. write_valid is low for pixels outside the screen.
// - Throughput is one byte per cycle while the receiver does not stall. The parser
//   register loads at the edge that transfers the byte completing a result, and
//   the address stage, whose 13 by 13 bit multiply of row and line stride sets the
//   path length, then loads the output register from the parser register.
// - When the receiver stalls, the output register and the parser register
//   both hold, after which in_ready_o drops; nothing is lost.
// - Reset clears the counters and loads the register defaults (width, height,
//   screen size and stride 1, offsets 0, bottom-up rows).
module bmp24_to_rgb565_pixel_writer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [b2r_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [b2r_pkg::DIM_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  b2r_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output b2r_pkg::out_item_t                  out_data_o
);
  import b2r_pkg::*;

  cfg_t       cfg_q;
  logic       ev_valid;
  logic       ev_ready;
  pix_event_t ev;
  logic       out_valid_q;
  out_item_t  out_q, out_d;
  logic [2*DIM_W-1:0] prod;
  logic [2*DIM_W-1:0] addr_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= DIM_W'(1);
      cfg_q.image_height  <= DIM_W'(1);
      cfg_q.top_first     <= 1'b0;
      cfg_q.dest_x        <= '0;
      cfg_q.dest_y        <= '0;
      cfg_q.screen_width  <= DIM_W'(1);
      cfg_q.screen_height <= DIM_W'(1);
      cfg_q.line_stride   <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i;
        REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i;
        REG_TOP_FIRST:     cfg_q.top_first     <= cfg_data_i[0];
        REG_DEST_X:        cfg_q.dest_x        <= cfg_data_i;
        REG_DEST_Y:        cfg_q.dest_y        <= cfg_data_i;
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i;
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i;
        REG_LINE_STRIDE:   cfg_q.line_stride   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  b2r_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .ev_valid_o (ev_valid),
    .ev_ready_i (ev_ready),
    .ev_o       (ev)
  );

  assign ev_ready = !out_valid_q || out_ready_i;

  // Linear address: row times stride plus column, wrapped to the address width; zero off screen.
  always_comb begin
    prod     = (2*DIM_W)'(ev.pix_row) * (2*DIM_W)'(cfg_q.line_stride);
    addr_sum = prod + (2*DIM_W)'(ev.pix_col);
    out_d.write_valid   = ev.on_screen;
    out_d.pixel_address = ev.on_screen ? addr_sum[ADDR_W-1:0] : '0;
    out_d.pixel_rgb565  = ev.rgb565;
    out_d.image_done    = ev.image_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ev_valid && ev_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_valid && ev_ready) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Off-screen pixels and pad results carry a zero address.
  a_offscreen_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.write_valid |-> out_q.pixel_address == '0)
    else $error("nonzero address on a result without a write");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("result changed while the receiver was stalled");

  a_event_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid && ev_ready |=> out_valid_q)
    else $error("pixel event taken without reaching the output register");

endmodule

[hdl/b2r_parse.sv]
// Byte parser: tracks phase, padding and row/column counters, packs RGB565
// and clips against the screen. Registers one pixel event. Depends on b2r_pkg.
`timescale 1ns / 1ps

module b2r_parse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b2r_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  b2r_pkg::in_item_t      in_data_i,
  output logic                   ev_valid_o,
  input  logic                   ev_ready_i,
  output b2r_pkg::pix_event_t    ev_o
);
  import b2r_pkg::*;

  logic [DIM_W-1:0] col_q, col_d, col_e;
  logic [DIM_W-1:0] row_q, row_d, row_e;
  byte_phase_e      phase_q, phase_d, phase_e;
  logic [1:0]       pad_q, pad_d, pad_e;
  logic [7:0]       blue_q, blue_d, blue_e;
  logic [7:0]       green_q, green_d, green_e;

  logic             ev_valid_q;
  pix_event_t       ev_q;
  pix_event_t       res;
  logic             res_valid;
  logic             accept;

  logic [DIM_W-1:0] w, h;
  logic [DIM_W:0]   col_inc;
  logic [1:0]       row_rem;
  logic [1:0]       pad_amt;
  logic signed [DIM_W+1:0] sx, sy;
  logic [7:0]       b;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W:0] lim;
    lim = (DIM_W+1)'(MAX_DIM);
    if ({1'b0, v} > lim) begin
      return lim[DIM_W-1:0];
    end
    return v;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !ev_valid_q || ev_ready_i;
  assign b          = in_data_i.pixel_byte;

  always_comb begin
    w = clamp_dim(cfg_i.image_width);
    h = clamp_dim(cfg_i.image_height);

    // A start marker clears the counters before this byte is handled.
    col_e   = in_data_i.start_image ? '0 : col_q;
    row_e   = in_data_i.start_image ? '0 : row_q;
    phase_e = in_data_i.start_image ? PH_BLUE : phase_q;
    pad_e   = in_data_i.start_image ? '0 : pad_q;
    blue_e  = in_data_i.start_image ? '0 : blue_q;
    green_e = in_data_i.start_image ? '0 : green_q;

    col_d   = col_e;
    row_d   = row_e;
    phase_d = phase_e;
    pad_d   = pad_e;
    blue_d  = blue_e;
    green_d = green_e;

    res_valid = 1'b0;
    res       = '0;

    col_inc = {1'b0, col_e} + (DIM_W+1)'(1);
    row_rem = 2'(w[1:0] * 2'(BYTES_PER_PIXEL));
    pad_amt = 2'(~row_rem + 2'd1);

    sx = $signed({{2{cfg_i.dest_x[DIM_W-1]}}, cfg_i.dest_x}) + $signed({2'b00, col_e});
    if (cfg_i.top_first) begin
      sy = $signed({{2{cfg_i.dest_y[DIM_W-1]}}, cfg_i.dest_y}) + $signed({2'b00, row_e});
    end else begin
      sy = $signed({{2{cfg_i.dest_y[DIM_W-1]}}, cfg_i.dest_y}) + $signed({2'b00, h})
           - $signed({2'b00, row_e}) - $signed((DIM_W+2)'(1));
    end

    if (row_e >= h) begin
      // Past the last row: byte is dropped until the next start marker.
    end else if (pad_e != 2'd0) begin
      pad_d = pad_e - 2'd1;
      if (pad_d == 2'd0) begin
        row_d = row_e + DIM_W'(1);
      end
      if (row_d == h) begin
        res_valid      = 1'b1;
        res.image_done = 1'b1;
      end
    end else begin
      case (phase_e)
        PH_BLUE: begin
          blue_d  = b;
          phase_d = PH_GREEN;
        end
        PH_GREEN: begin
          green_d = b;
          phase_d = PH_RED;
        end
        default: begin
          phase_d   = PH_BLUE;
          res_valid = 1'b1;
          res.rgb565 = {b[7:3], green_e[7:2], blue_e[7:3]};
          res.on_screen = !sx[DIM_W+1] && (sx[DIM_W:0] < {1'b0, cfg_i.screen_width}) &&
                          !sy[DIM_W+1] && (sy[DIM_W:0] < {1'b0, cfg_i.screen_height});
          res.pix_col = sx[DIM_W-1:0];
          res.pix_row = sy[DIM_W-1:0];
          if (col_inc >= {1'b0, w}) begin
            col_d = '0;
            if (pad_amt != 2'd0) begin
              pad_d = pad_amt;
            end else begin
              row_d = row_e + DIM_W'(1);
            end
          end else begin
            col_d = col_inc[DIM_W-1:0];
          end
          res.image_done = (row_d == h);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= PH_BLUE;
      pad_q   <= '0;
      blue_q  <= '0;
      green_q <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      pad_q   <= pad_d;
      blue_q  <= blue_d;
      green_q <= green_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (accept && res_valid) begin
      ev_valid_q <= 1'b1;
    end else if (ev_ready_i) begin
      ev_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      ev_q <= res;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

  // Padding is only scheduled after a full pixel, so the phase must be blue.
  a_pad_at_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q != 2'd0 |-> phase_q == PH_BLUE)
    else $error("pad bytes pending in the middle of a pixel");

  // A pixel event waiting on the address stage must not be overwritten.
  a_event_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_q && !ev_ready_i |=> ev_valid_q && $stable(ev_q))
    else $error("pixel event lost while the address stage was stalled");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BLUE || phase_q == PH_GREEN || phase_q == PH_RED)
    else $error("byte phase left its legal values");

endmodule

[test/testbench.sv]
// Self-checking testbench for bmp24_to_rgb565_pixel_writer: drives BMP pixel
// bytes, predicts each pixel write and image-done flag, and checks every output.
// Depends on b2r_pkg and the pixel writer RTL.
`timescale 1ns / 1ps

module testbench;
  import b2r_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int ITEM_TARGET  = 1150;
  localparam int TAIL_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  cfg_reg_e   cfg_index_i = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;

  bmp24_to_rgb565_pixel_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Register copy and parser state of the predictor.
  cfg_t        shadow = '{image_width: 13'd1, image_height: 13'd1, top_first: 1'b0,
                          dest_x: '0, dest_y: '0, screen_width: 13'd1,
                          screen_height: 13'd1, line_stride: 13'd1};
  int          col_cnt = 0;
  int          row_cnt = 0;
  int          pad_left = 0;
  byte_phase_e phase = PH_BLUE;
  logic [7:0]  held_blue = '0;
  logic [7:0]  held_green = '0;

  in_item_t    pending_bytes[$];
  out_item_t   expected_writes[$];
  out_item_t   want_write;
  bit          byte_taken = 1'b0;
  bit          failed = 1'b0;
  int          idle_odds = 4;
  int          send_hold = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  function automatic int dim_clamp(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  task automatic predict_pixel_write(input in_item_t itm);
    int w, h, pad, sx, sy, sw, sh, stride;
    longint lin;
    out_item_t r;
    w = dim_clamp(shadow.image_width);
    h = dim_clamp(shadow.image_height);
    if (itm.start_image) begin
      col_cnt = 0;
      row_cnt = 0;
      pad_left = 0;
      phase = PH_BLUE;
      held_blue = '0;
      held_green = '0;
    end
    if (row_cnt >= h) return;
    r = '0;
    if (pad_left != 0) begin
      pad_left--;
      if (pad_left == 0) row_cnt++;
      // A pad byte that ends the image still reports completion.
      if (row_cnt == h) begin
        r.image_done = 1'b1;
        expected_writes.push_back(r);
      end
      return;
    end
    case (phase)
      PH_BLUE: begin
        held_blue = itm.pixel_byte;
        phase = PH_GREEN;
      end
      PH_GREEN: begin
        held_green = itm.pixel_byte;
        phase = PH_RED;
      end
      default: begin
        phase = PH_BLUE;
        sx = $signed(shadow.dest_x);
        sx += col_cnt;
        sy = $signed(shadow.dest_y);
        sy += shadow.top_first ? row_cnt : h - 1 - row_cnt;
        sw = shadow.screen_width;
        sh = shadow.screen_height;
        stride = shadow.line_stride;
        r.pixel_rgb565 = {itm.pixel_byte[7:3], held_green[7:2], held_blue[7:3]};
        if (sx >= 0 && sx < sw && sy >= 0 && sy < sh) begin
          r.write_valid = 1'b1;
          lin = longint'(sy) * longint'(stride) + longint'(sx);
          r.pixel_address = lin[ADDR_W-1:0];
        end
        col_cnt++;
        if (col_cnt >= w) begin
          col_cnt = 0;
          pad = (4 - ((w * BYTES_PER_PIXEL) % 4)) % 4;
          if (pad != 0) pad_left = pad;
          else row_cnt++;
        end
        r.image_done = (row_cnt == h);
        expected_writes.push_back(r);
      end
    endcase
  endtask

  // Output checks come first; a byte accepted at this edge cannot have a result yet.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected pixel write transfer: %p", out_data_o);
          failed = 1'b1;
        end else begin
          want_write = expected_writes.pop_front();
          if (out_data_o.write_valid !== want_write.write_valid) begin
            $error("write_valid: expected %0d, got %0d",
                   want_write.write_valid, out_data_o.write_valid);
            failed = 1'b1;
          end
          if (out_data_o.pixel_address !== want_write.pixel_address) begin
            $error("pixel_address: expected %0d, got %0d",
                   want_write.pixel_address, out_data_o.pixel_address);
            failed = 1'b1;
          end
          if (out_data_o.pixel_rgb565 !== want_write.pixel_rgb565) begin
            $error("pixel_rgb565: expected 0x%04h, got 0x%04h",
                   want_write.pixel_rgb565, out_data_o.pixel_rgb565);
            failed = 1'b1;
          end
          if (out_data_o.image_done !== want_write.image_done) begin
            $error("image_done: expected %0d, got %0d",
                   want_write.image_done, out_data_o.image_done);
            failed = 1'b1;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_pixel_write(in_data_i);
        byte_taken = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || byte_taken) begin
      byte_taken = 1'b0;
      if (send_hold > 0) begin
        send_hold--;
        in_valid_i <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        send_hold = $urandom_range(0, 6);
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic first);
    in_item_t itm;
    itm.pixel_byte = b;
    itm.start_image = first;
    pending_bytes.push_back(itm);
  endfunction

  // Queues one image of random pixels, optionally cut short, and returns its length.
  function automatic int queue_image(input int w_px, input int rows, input int cut);
    int per_row, total;
    per_row = (w_px == 0) ? 3 : w_px * 3 + (4 - (w_px * 3) % 4) % 4;
    total = per_row * rows;
    if (cut > 0 && cut < total) total = cut;
    for (int k = 0; k < total; k++) push_byte(8'($urandom), k == 0);
    return total;
  endfunction

  // Sampled at the rising edge, where the driver never changes the queue or valid.
  task automatic settle();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_writes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
  endtask

  task automatic program_regs(input int w, input int h, input int td, input int dx,
                              input int dy, input int sw, input int sh, input int st);
    settle();
    shadow.image_width = 13'(w);
    shadow.image_height = 13'(h);
    shadow.top_first = 1'(td);
    shadow.dest_x = 13'(dx);
    shadow.dest_y = 13'(dy);
    shadow.screen_width = 13'(sw);
    shadow.screen_height = 13'(sh);
    shadow.line_stride = 13'(st);
    put_reg(REG_IMAGE_WIDTH, shadow.image_width);
    put_reg(REG_IMAGE_HEIGHT, shadow.image_height);
    put_reg(REG_TOP_FIRST, {12'($urandom), shadow.top_first});
    put_reg(REG_DEST_X, shadow.dest_x);
    put_reg(REG_DEST_Y, shadow.dest_y);
    put_reg(REG_SCREEN_WIDTH, shadow.screen_width);
    put_reg(REG_SCREEN_HEIGHT, shadow.screen_height);
    put_reg(REG_LINE_STRIDE, shadow.line_stride);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int w, h, dx, dy, sw, sh, st, image_items;
    image_items = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: a 1x1 image with one pad byte, then bytes past the end.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);

    // 2x2 bottom-up image clipped on the left and bottom, all-zero and all-one pixels.
    program_regs(2, 2, 0, -1, 1, 1, 2, 8191);
    push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0); push_byte(8'hA5, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h3C, 1'b0); push_byte(8'hC3, 1'b0);
    push_byte(8'h7E, 1'b0); push_byte(8'h81, 1'b0);

    // Zero width makes every pixel a whole row.
    program_regs(0, 3, 1, 0, 0, 4, 4, 5);
    void'(queue_image(0, 3, 0));

    // Zero height ignores everything.
    program_regs(2, 0, 0, 1, 1, 8, 8, 8);
    push_byte(8'($urandom), 1'b1);
    repeat (4) push_byte(8'($urandom), 1'b0);

    // Rows past 4096 with the widest stride push the address past its width.
    program_regs(2, 4, 1, 4094, 4095, 8191, 8191, 8191);
    void'(queue_image(2, 4, 0));

    // Saturated height moves the bottom-up row origin; only the first rows are sent.
    program_regs(1, 8191, 0, 0, -4090, 4, 8, 4);
    void'(queue_image(1, MAX_DIM, 40));

    // Saturated width: the opening pixels of a 4096-pixel row, left edge clipped.
    program_regs(8191, 1, 1, -2, 0, 8191, 1, 1);
    void'(queue_image(MAX_DIM, 1, 48));

    while (image_items < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) w = 0;
      else if ($urandom_range(0, 4) == 0) w = $urandom_range(7, 16);
      else w = $urandom_range(1, 6);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      dx = ($urandom_range(0, 3) == 0) ? 13'($urandom) : $urandom_range(0, 12) - 6;
      dy = ($urandom_range(0, 3) == 0) ? 13'($urandom) : $urandom_range(0, 12) - 6;
      sw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 8);
      sh = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 8);
      st = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 16);
      program_regs(w, h, $urandom_range(0, 1), dx, dy, sw, sh, st);
      if (image_items >= ITEM_TARGET - TAIL_ITEMS) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 3;
          default: idle_odds = 8;
        endcase
      end
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 8)) push_byte(8'($urandom), $urandom_range(0, 2) == 0);
          1: image_items += queue_image(w, h, $urandom_range(1, 20));
          default: begin
            image_items += queue_image(w, h, 0);
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
          end
        endcase
      end
    end

    settle();
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
